@@ src/fpp_pkg.sv @@
// Package for the framed packet parser: sizes, result codes, register
// indexes and the job record passed from the front to the back.
// Depends on nothing.
package fpp_pkg;

  localparam int BUF_DEPTH  = 32;
  localparam int ADDR_W     = $clog2(BUF_DEPTH);
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Result kinds
  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_CHK_ERR  = 2'd1,
    EV_FOOT_ERR = 2'd2
  } event_kind_e;

  // Input opcodes
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [7:0]  HEADER_RST  = 8'd170;
  localparam logic [7:0]  FOOTER_RST  = 8'd187;
  localparam logic [15:0] TIMEOUT_RST = 16'd100;

  // One finished frame or error, queued for the back
  typedef struct packed {
    event_kind_e      kind;
    logic [7:0]       command;
    logic [LEN_W-1:0] length;
  } job_t;

endpackage

@@ src/fpp_stream_if.sv @@
// Handshake channels of the framed packet parser: input words and result
// words. Depends on fpp_pkg.
interface fpp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface fpp_out_if import fpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [7:0]        command_code;
  logic [LEN_W-1:0]  payload_length;
  logic [7:0]        data_value;
  logic [ADDR_W-1:0] data_position;
  logic              last_of_run;

  modport source (output valid, output event_kind, output command_code,
                  output payload_length, output data_value,
                  output data_position, output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input command_code,
                  input payload_length, input data_value,
                  input data_position, input last_of_run, output ready);
endinterface

@@ src/fpp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fpp_front.sv @@
// Front of the parser: configuration registers, frame deframing, checksum,
// timeout and buffer writes; pushes one job per frame end. Depends on fpp_pkg.
module fpp_front import fpp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  q_full_i,
  input  logic                  back_busy_i,
  output logic                  push_o,
  output job_t                  push_job_o,
  output logic                  ram_we_o,
  output logic [ADDR_W-1:0]     ram_waddr_o,
  output logic [7:0]            ram_wdata_o
);

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_HEAD = 6'b000010,
    PH_CMD  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CHK  = 6'b010000,
    PH_FOOT = 6'b100000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [7:0]       header_q, footer_q;
  logic [15:0]      timeout_q;
  logic [7:0]       cmd_q, cmd_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] fill_q, fill_d;
  logic [7:0]       xor_q, xor_d;
  logic [15:0]      quiet_q, quiet_d;
  logic             accept;
  logic [LEN_W-1:0] fill_inc;

  // Stall on a full queue, and keep buffer writes off while the back reads it
  assign in_ready_o = !q_full_i && !(phase_q == PH_DATA && back_busy_i);
  assign accept     = in_valid_i && in_ready_o;
  assign fill_inc   = fill_q + LEN_W'(1);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= HEADER_RST;
      footer_q  <= FOOTER_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEADER:  header_q  <= cfg_data_i[7:0];
        CFG_FOOTER:  footer_q  <= cfg_data_i[7:0];
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Parse one word
  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    fill_d      = fill_q;
    xor_d       = xor_q;
    quiet_d     = quiet_q;
    push_o      = 1'b0;
    push_job_o  = '{kind: EV_DATA, command: cmd_q, length: len_q};
    ram_we_o    = 1'b0;
    ram_waddr_o = fill_q[ADDR_W-1:0];
    ram_wdata_o = rx_byte_i;
    if (accept) begin
      if (opcode_i == OP_TICK) begin
        if (quiet_q != 16'hFFFF) begin
          quiet_d = quiet_q + 16'd1;
        end
        if (phase_q != PH_IDLE && quiet_d > timeout_q) begin
          phase_d = PH_IDLE;
        end
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (rx_byte_i == header_q) begin
              xor_d   = 8'd0;
              phase_d = PH_HEAD;
            end
          end
          PH_HEAD: begin
            cmd_d   = rx_byte_i;
            xor_d   = rx_byte_i;
            phase_d = PH_CMD;
          end
          PH_CMD: begin
            xor_d = xor_q ^ rx_byte_i;
            if (rx_byte_i > 8'(BUF_DEPTH)) begin
              phase_d = PH_IDLE;
            end else begin
              len_d   = rx_byte_i[LEN_W-1:0];
              fill_d  = '0;
              phase_d = (rx_byte_i == 8'd0) ? PH_CHK : PH_DATA;
            end
          end
          PH_DATA: begin
            ram_we_o = 1'b1;
            fill_d   = fill_inc;
            xor_d    = xor_q ^ rx_byte_i;
            if (fill_inc >= len_q) begin
              phase_d = PH_CHK;
            end
          end
          PH_CHK: begin
            if (rx_byte_i == xor_q) begin
              phase_d = PH_FOOT;
            end else begin
              push_o          = 1'b1;
              push_job_o.kind = EV_CHK_ERR;
              phase_d         = PH_IDLE;
            end
          end
          PH_FOOT: begin
            push_o          = 1'b1;
            push_job_o.kind = (rx_byte_i == footer_q) ? EV_DATA : EV_FOOT_ERR;
            phase_d         = PH_IDLE;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      // Any phase change restarts the quiet count
      if (phase_d != phase_q) begin
        quiet_d = 16'd0;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      len_q   <= '0;
      fill_q  <= '0;
      xor_q   <= '0;
      quiet_q <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      xor_q   <= xor_d;
      quiet_q <= quiet_d;
    end
  end

endmodule

@@ src/fpp_queue.sv @@
// Two-entry job queue between the parser front and the result back.
// Depends on fpp_pkg.
module fpp_queue import fpp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  job_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = entry_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ src/fpp_back.sv @@
// Back of the parser: takes jobs from the queue, reads the payload buffer
// and drives the result register. Depends on fpp_pkg.
module fpp_back import fpp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              busy_o,
  output logic              ram_re_o,
  output logic [ADDR_W-1:0] ram_raddr_o,
  input  logic [7:0]        ram_rdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        event_kind_o,
  output logic [7:0]        command_code_o,
  output logic [LEN_W-1:0]  payload_length_o,
  output logic [7:0]        data_value_o,
  output logic [ADDR_W-1:0] data_position_o,
  output logic              last_of_run_o
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_SEND = 3'b100
  } back_state_e;

  back_state_e       state_q, state_d;
  job_t              job_q, job_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [1:0]        kind_d;
  logic [7:0]        cmd_d, val_d;
  logic [LEN_W-1:0]  len_d;
  logic [ADDR_W-1:0] pos_d;
  logic              last_d;
  logic [1:0]        kind_q;
  logic [7:0]        cmd_q, val_q;
  logic [LEN_W-1:0]  len_q;
  logic [ADDR_W-1:0] pos_q;
  logic              last_q;
  logic              out_free;
  logic              idx_last;

  assign out_free    = !out_valid_q || out_ready_i;
  assign busy_o      = (state_q != BK_IDLE);
  assign ram_re_o    = (state_q == BK_READ);
  assign ram_raddr_o = idx_q;
  assign idx_last    = ((LEN_W'(idx_q) + LEN_W'(1)) == job_q.length);

  // Sequence jobs into result words
  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    idx_d    = idx_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    kind_d   = EV_DATA;
    cmd_d    = head_i.command;
    len_d    = head_i.length;
    val_d    = 8'd0;
    pos_d    = '0;
    last_d   = 1'b1;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          if (head_i.kind != EV_DATA || head_i.length == '0) begin
            if (out_free) begin
              pop_o    = 1'b1;
              out_load = 1'b1;
              kind_d   = head_i.kind;
            end
          end else begin
            pop_o   = 1'b1;
            job_d   = head_i;
            idx_d   = '0;
            state_d = BK_READ;
          end
        end
      end
      BK_READ: state_d = BK_SEND;
      BK_SEND: begin
        cmd_d  = job_q.command;
        len_d  = job_q.length;
        val_d  = ram_rdata_i;
        pos_d  = idx_q;
        last_d = idx_last;
        if (out_free) begin
          out_load = 1'b1;
          if (idx_last) begin
            state_d = BK_IDLE;
          end else begin
            idx_d   = idx_q + ADDR_W'(1);
            state_d = BK_READ;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (out_load) begin
      kind_q <= kind_d;
      cmd_q  <= cmd_d;
      len_q  <= len_d;
      val_q  <= val_d;
      pos_q  <= pos_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = kind_q;
  assign command_code_o   = cmd_q;
  assign payload_length_o = len_q;
  assign data_value_o     = val_q;
  assign data_position_o  = pos_q;
  assign last_of_run_o    = last_q;

endmodule

@@ src/framed_packet_parser.sv @@
// Framed packet parser: one input word (byte or tick) accepted per cycle
// unless the queue is full or payload writes wait on the back. A frame end
// is pushed into the two-entry job queue as its last word is accepted; data
// runs give one result per byte via the buffer's registered read. Reset clears
// all control state and restores the register defaults; the payload buffer is
// not cleared. Depends on fpp_pkg and fpp_stream_if.
module framed_packet_parser import fpp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fpp_in_if.sink                in_if,
  fpp_out_if.source             out_if
);

  logic              q_full, q_empty, push, pop, back_busy;
  job_t              push_job, head;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // Parser front
  fpp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .opcode_i    (in_if.opcode),
    .rx_byte_i   (in_if.rx_byte),
    .q_full_i    (q_full),
    .back_busy_i (back_busy),
    .push_o      (push),
    .push_job_o  (push_job),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  // Job queue
  fpp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // Payload buffer
  fpp_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result back
  fpp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .empty_i          (q_empty),
    .pop_o            (pop),
    .busy_o           (back_busy),
    .ram_re_o         (ram_re),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .out_valid_o      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .event_kind_o     (out_if.event_kind),
    .command_code_o   (out_if.command_code),
    .payload_length_o (out_if.payload_length),
    .data_value_o     (out_if.data_value),
    .data_position_o  (out_if.data_position),
    .last_of_run_o    (out_if.last_of_run)
  );

endmodule
